### hdl/tgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgs_pkg: shared types and constants of the tree gather schedule block
// field widths, action codes, register indexes, control word and program rom
// ----------------------------------------------------------------------------
package tgs_pkg;

   localparam int RANK_W     = 10;
   localparam int NP_W       = 11;
   localparam int ELEM_W     = 16;
   localparam int KIND_W     = 2;
   localparam int ROUND_W    = 4;
   localparam int FIELD_W    = 26;
   localparam int LG_W       = 4;
   localparam int PC_W       = 4;
   localparam int PROD_W     = ELEM_W + NP_W;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // action codes
   localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RECV = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SHUF = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_PROC_COUNT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROOT_RANK  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ELEM_COUNT = 2'd2;

   // program steps
   localparam logic [PC_W-1:0] S_IDLE   = 4'd0;
   localparam logic [PC_W-1:0] S_TREE   = 4'd1;
   localparam logic [PC_W-1:0] S_TSEND  = 4'd2;
   localparam logic [PC_W-1:0] S_FSHUF  = 4'd3;
   localparam logic [PC_W-1:0] S_FRECV0 = 4'd4;
   localparam logic [PC_W-1:0] S_FRECVM = 4'd5;
   localparam logic [PC_W-1:0] S_FSEND0 = 4'd6;
   localparam logic [PC_W-1:0] S_FSENDM = 4'd7;
   localparam logic [PC_W-1:0] S_END    = 4'd8;

   // emit conditions
   localparam logic [2:0] EC_NEVER     = 3'd0;
   localparam logic [2:0] EC_TREE_RECV = 3'd1;
   localparam logic [2:0] EC_TREE_SEND = 3'd2;
   localparam logic [2:0] EC_SHUF      = 3'd3;
   localparam logic [2:0] EC_RECV0     = 3'd4;
   localparam logic [2:0] EC_RECVM     = 3'd5;
   localparam logic [2:0] EC_SEND0     = 3'd6;
   localparam logic [2:0] EC_SENDM     = 3'd7;

   // partner selects
   localparam logic [2:0] PS_ZERO      = 3'd0;
   localparam logic [2:0] PS_PEER_UP   = 3'd1;
   localparam logic [2:0] PS_PEER_DOWN = 3'd2;
   localparam logic [2:0] PS_SELF      = 3'd3;
   localparam logic [2:0] PS_MID       = 3'd4;
   localparam logic [2:0] PS_ROOT      = 3'd5;

   // offset selects
   localparam logic [1:0] OS_ZERO = 2'd0;
   localparam logic [1:0] OS_GAP  = 2'd1;
   localparam logic [1:0] OS_MID  = 2'd2;

   // size selects
   localparam logic [2:0] SZ_ZERO   = 3'd0;
   localparam logic [2:0] SZ_RECV   = 3'd1;
   localparam logic [2:0] SZ_SEND   = 3'd2;
   localparam logic [2:0] SZ_MID    = 3'd3;
   localparam logic [2:0] SZ_SECOND = 3'd4;

   // round selects
   localparam logic [1:0] RS_ZERO = 2'd0;
   localparam logic [1:0] RS_GAP  = 2'd1;
   localparam logic [1:0] RS_LG   = 2'd2;

   // jump conditions
   localparam logic [1:0] JC_NEVER     = 2'd0;
   localparam logic [1:0] JC_TREE_EXIT = 2'd1;
   localparam logic [1:0] JC_ROOT_ZERO = 2'd2;
   localparam logic [1:0] JC_ALWAYS    = 2'd3;

   typedef struct packed {
      logic            wait_req;
      logic            hold;
      logic            gap_inc;
      logic            flush;
      logic [2:0]      emit_sel;
      logic [KIND_W-1:0] kind;
      logic [2:0]      partner_sel;
      logic [1:0]      offset_sel;
      logic [2:0]      size_sel;
      logic [1:0]      round_sel;
      logic [1:0]      jump_sel;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ROUND_W-1:0] round;
      logic [RANK_W-1:0]  partner;
      logic [FIELD_W-1:0] offset;
      logic [FIELD_W-1:0] total;
   } action_type;

   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '0;
      w.kind = KIND_NONE;
      case (pc)
         S_IDLE: begin
            w.wait_req = 1'b1;
         end
         S_TREE: begin
            // receive round, loops until the rank sends or runs out of rounds
            w.hold        = 1'b1;
            w.gap_inc     = 1'b1;
            w.emit_sel    = EC_TREE_RECV;
            w.kind        = KIND_RECV;
            w.partner_sel = PS_PEER_UP;
            w.offset_sel  = OS_GAP;
            w.size_sel    = SZ_RECV;
            w.round_sel   = RS_GAP;
            w.jump_sel    = JC_TREE_EXIT;
            w.target      = S_TSEND;
         end
         S_TSEND: begin
            w.emit_sel    = EC_TREE_SEND;
            w.kind        = KIND_SEND;
            w.partner_sel = PS_PEER_DOWN;
            w.offset_sel  = OS_ZERO;
            w.size_sel    = SZ_SEND;
            w.round_sel   = RS_GAP;
            w.jump_sel    = JC_ROOT_ZERO;
            w.target      = S_END;
         end
         S_FSHUF: begin
            w.emit_sel    = EC_SHUF;
            w.kind        = KIND_SHUF;
            w.partner_sel = PS_SELF;
            w.offset_sel  = OS_MID;
            w.size_sel    = SZ_SECOND;
            w.round_sel   = RS_LG;
         end
         S_FRECV0: begin
            w.emit_sel    = EC_RECV0;
            w.kind        = KIND_RECV;
            w.partner_sel = PS_ZERO;
            w.offset_sel  = OS_ZERO;
            w.size_sel    = SZ_MID;
            w.round_sel   = RS_LG;
         end
         S_FRECVM: begin
            w.emit_sel    = EC_RECVM;
            w.kind        = KIND_RECV;
            w.partner_sel = PS_MID;
            w.offset_sel  = OS_MID;
            w.size_sel    = SZ_SECOND;
            w.round_sel   = RS_LG;
         end
         S_FSEND0: begin
            w.emit_sel    = EC_SEND0;
            w.kind        = KIND_SEND;
            w.partner_sel = PS_ROOT;
            w.offset_sel  = OS_ZERO;
            w.size_sel    = SZ_MID;
            w.round_sel   = RS_LG;
         end
         S_FSENDM: begin
            w.emit_sel    = EC_SENDM;
            w.kind        = KIND_SEND;
            w.partner_sel = PS_ROOT;
            w.offset_sel  = OS_ZERO;
            w.size_sel    = SZ_SECOND;
            w.round_sel   = RS_LG;
         end
         S_END: begin
            w.flush    = 1'b1;
            w.jump_sel = JC_ALWAYS;
            w.target   = S_IDLE;
         end
         default: begin
            w.jump_sel = JC_ALWAYS;
            w.target   = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

### hdl/tree_gather_schedule.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_gather_schedule: binomial tree gather schedule generator
// takes one rank and emits its ordered list of send, receive and shuffle beats
// ----------------------------------------------------------------------------
// A request beat carries one rank number; the block answers with that rank's
// gather schedule, one response beat per action, the final beat flagged by
// rsp_last_action (a rank with no actions gets a single no-action beat).
// Control runs from a small program rom with a step counter: one step per
// tree round, one step for a send, five steps for the root's final round
// (skipped when the root is rank 0), an entry step and a closing step. A
// request holds the sequencer until its closing step is through, and longer
// while the response side stalls; a rank takes the receiving side in at most
// 10 tree rounds. One action is held back in a pending register so that the
// last flag is known when it leaves; the response register lets the next
// request start while the final beat still waits. Configuration is written
// through csr_write_en / csr_index / csr_wdata while no request is in
// flight.
module tree_gather_schedule #(
   parameter int MAX_PROCS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tgs_pkg::RANK_W-1:0]         req_my_rank,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tgs_pkg::KIND_W-1:0]         rsp_action_kind,
   output logic [tgs_pkg::ROUND_W-1:0]        rsp_round_number,
   output logic [tgs_pkg::RANK_W-1:0]         rsp_partner_rank,
   output logic [tgs_pkg::FIELD_W-1:0]        rsp_elem_offset,
   output logic [tgs_pkg::FIELD_W-1:0]        rsp_elem_total,
   output logic                               rsp_last_action,
   // configuration write port
   input  logic                               csr_write_en,
   input  logic [tgs_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [tgs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tgs_pkg::*;

   localparam int GAP_W = NP_W + 1;
   localparam int SUM_W = NP_W + 3;

   // configuration registers
   logic [NP_W-1:0]    proc_count_ff, proc_count_in;
   logic [RANK_W-1:0]  root_rank_ff,  root_rank_in;
   logic [ELEM_W-1:0]  elem_count_ff, elem_count_in;

   // sequencer and per-request state
   logic [PC_W-1:0]    pc_ff,   pc_in;
   logic [RANK_W-1:0]  me_ff,   me_in;
   logic [NP_W-1:0]    np_ff,   np_in;
   logic [NP_W-1:0]    mid_ff,  mid_in;
   logic [LG_W-1:0]    lg_ff,   lg_in;
   logic [LG_W-1:0]    glog_ff, glog_in;

   // pending action and response register
   action_type         pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in;
   action_type         rsp_ff, rsp_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_valid_ff, rsp_valid_in;

   ctrl_word_type      ctrl;

   // request setup
   logic [NP_W-1:0]    np_calc;
   logic [NP_W-1:0]    nm1;
   logic [LG_W-1:0]    lg_calc;
   logic [NP_W-1:0]    mid_calc;

   // datapath
   logic [GAP_W-1:0]   gap;
   logic [NP_W-1:0]    max_gap;
   logic               gap_over;
   logic [SUM_W-1:0]   stride_mask;
   logic               sender;
   logic               tree_exit;
   logic [SUM_W-1:0]   me_wide;
   logic [SUM_W-1:0]   np_wide;
   logic [SUM_W-1:0]   peer_up;
   logic               peer_ok;
   logic [SUM_W-1:0]   recv_stop;
   logic [SUM_W-1:0]   send_stop;
   logic [NP_W-1:0]    recv_size;
   logic [NP_W-1:0]    send_size;
   logic [NP_W-1:0]    second;
   logic               root_nz;
   logic               me_is_root;
   logic               mid_is_root;
   logic               me_is_mid;
   logic               emit;
   logic               jump_take;
   logic               out_free;
   logic               stall;
   logic [NP_W-1:0]    factor;
   logic [PROD_W-1:0]  product;
   logic [LG_W-1:0]    off_shift;
   logic               off_en;
   logic [PROD_W-1:0]  off_wide;
   action_type         new_act;
   action_type         none_act;

   assign ctrl = ucode_rom(pc_ff);

   // clamp process count and find the midpoint
   always_comb begin
      if (proc_count_ff == '0) begin
         np_calc = NP_W'(1);
      end else if (32'(proc_count_ff) > MAX_PROCS) begin
         np_calc = NP_W'(MAX_PROCS);
      end else begin
         np_calc = proc_count_ff;
      end
      nm1     = np_calc - NP_W'(1);
      lg_calc = '0;
      for (int i = 0; i < NP_W; i++) begin
         if (nm1[i]) begin
            lg_calc = LG_W'(i + 1);
         end
      end
      mid_calc = (lg_calc == '0) ? '0 : (NP_W'(1) << (lg_calc - LG_W'(1)));
   end

   // tree round arithmetic
   always_comb begin
      gap         = GAP_W'(1) << glog_ff;
      root_nz     = (root_rank_ff != '0);
      max_gap     = root_nz ? (mid_ff >> 1) : mid_ff;
      gap_over    = (gap > GAP_W'(max_gap));
      stride_mask = (SUM_W'(gap) << 1) - SUM_W'(1);
      me_wide     = SUM_W'(me_ff);
      np_wide     = SUM_W'(np_ff);
      sender      = ((me_wide & stride_mask) != '0);
      tree_exit   = gap_over || sender;
      peer_up     = me_wide + SUM_W'(gap);
      peer_ok     = (peer_up < np_wide);
      // receive chunk clipped at the process count
      recv_stop   = peer_up + SUM_W'(gap);
      if (recv_stop > np_wide) begin
         recv_stop = np_wide;
      end
      recv_size   = NP_W'(recv_stop - peer_up);
      // send chunk, empty for a rank beyond the process count
      send_stop   = (peer_up > np_wide) ? np_wide : peer_up;
      send_size   = (send_stop > me_wide) ? NP_W'(send_stop - me_wide) : '0;
      second      = np_ff - mid_ff;
      me_is_root  = (me_ff == root_rank_ff);
      mid_is_root = (NP_W'(root_rank_ff) == mid_ff);
      me_is_mid   = (NP_W'(me_ff) == mid_ff);
   end

   // control word decode
   always_comb begin
      case (ctrl.emit_sel)
         EC_TREE_RECV: emit = !tree_exit && peer_ok;
         EC_TREE_SEND: emit = !gap_over && sender;
         EC_SHUF:      emit = root_nz && me_is_root && mid_is_root;
         EC_RECV0:     emit = root_nz && me_is_root;
         EC_RECVM:     emit = root_nz && me_is_root && !mid_is_root;
         EC_SEND0:     emit = root_nz && (me_ff == '0);
         EC_SENDM:     emit = root_nz && me_is_mid && !mid_is_root;
         default:      emit = 1'b0;
      endcase
      case (ctrl.jump_sel)
         JC_TREE_EXIT: jump_take = tree_exit;
         JC_ROOT_ZERO: jump_take = !root_nz;
         JC_ALWAYS:    jump_take = 1'b1;
         default:      jump_take = 1'b0;
      endcase
   end

   // action assembly: one multiplier for the total, a shifter for the offset
   always_comb begin
      case (ctrl.size_sel)
         SZ_RECV:   factor = recv_size;
         SZ_SEND:   factor = send_size;
         SZ_MID:    factor = mid_ff;
         SZ_SECOND: factor = second;
         default:   factor = '0;
      endcase
      product = PROD_W'(elem_count_ff) * PROD_W'(factor);

      case (ctrl.offset_sel)
         OS_GAP: begin
            off_shift = glog_ff;
            off_en    = 1'b1;
         end
         OS_MID: begin
            off_shift = lg_ff - LG_W'(1);
            off_en    = (lg_ff != '0);
         end
         default: begin
            off_shift = '0;
            off_en    = 1'b0;
         end
      endcase
      off_wide = off_en ? (PROD_W'(elem_count_ff) << off_shift) : '0;

      new_act.kind   = ctrl.kind;
      new_act.offset = off_wide[FIELD_W-1:0];
      new_act.total  = product[FIELD_W-1:0];
      case (ctrl.partner_sel)
         PS_PEER_UP:   new_act.partner = peer_up[RANK_W-1:0];
         PS_PEER_DOWN: new_act.partner = RANK_W'(me_wide - SUM_W'(gap));
         PS_SELF:      new_act.partner = me_ff;
         PS_MID:       new_act.partner = mid_ff[RANK_W-1:0];
         PS_ROOT:      new_act.partner = root_rank_ff;
         default:      new_act.partner = '0;
      endcase
      case (ctrl.round_sel)
         RS_GAP:  new_act.round = glog_ff;
         RS_LG:   new_act.round = lg_ff;
         default: new_act.round = '0;
      endcase

      none_act.kind    = KIND_NONE;
      none_act.round   = '0;
      none_act.partner = '0;
      none_act.offset  = '0;
      none_act.total   = '0;
   end

   // sequencer, pending slot and response register
   always_comb begin
      pc_in         = pc_ff;
      me_in         = me_ff;
      np_in         = np_ff;
      mid_in        = mid_ff;
      lg_in         = lg_ff;
      glog_in       = glog_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff;

      out_free = !rsp_valid_ff || rsp_ready;
      // a new action pushes the pending one out, the closing step drains it
      stall    = ((emit && pend_valid_ff) || ctrl.flush) && !out_free;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (ctrl.wait_req) begin
         if (req_valid) begin
            me_in   = req_my_rank;
            np_in   = np_calc;
            mid_in  = mid_calc;
            lg_in   = lg_calc;
            glog_in = '0;
            pc_in   = pc_ff + PC_W'(1);
         end
      end else if (!stall) begin
         if (emit) begin
            if (pend_valid_ff) begin
               rsp_in       = pend_ff;
               rsp_last_in  = 1'b0;
               rsp_valid_in = 1'b1;
            end
            pend_in       = new_act;
            pend_valid_in = 1'b1;
         end
         if (ctrl.flush) begin
            rsp_in        = pend_valid_ff ? pend_ff : none_act;
            rsp_last_in   = 1'b1;
            rsp_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
         end
         if (jump_take) begin
            pc_in = ctrl.target;
         end else if (ctrl.hold) begin
            pc_in = pc_ff;
         end else begin
            pc_in = pc_ff + PC_W'(1);
         end
         if (ctrl.gap_inc && !jump_take) begin
            glog_in = glog_ff + LG_W'(1);
         end
      end
   end

   // configuration writes
   always_comb begin
      proc_count_in = proc_count_ff;
      root_rank_in  = root_rank_ff;
      elem_count_in = elem_count_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_PROC_COUNT: proc_count_in = csr_wdata[NP_W-1:0];
            CSR_ROOT_RANK:  root_rank_in  = csr_wdata[RANK_W-1:0];
            CSR_ELEM_COUNT: elem_count_in = csr_wdata[ELEM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_count_ff <= NP_W'(1);
         root_rank_ff  <= '0;
         elem_count_ff <= ELEM_W'(1);
         pc_ff         <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         proc_count_ff <= proc_count_in;
         root_rank_ff  <= root_rank_in;
         elem_count_ff <= elem_count_in;
         pc_ff         <= pc_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      me_ff       <= me_in;
      np_ff       <= np_in;
      mid_ff      <= mid_in;
      lg_ff       <= lg_in;
      glog_ff     <= glog_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready        = ctrl.wait_req;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action_kind  = rsp_ff.kind;
   assign rsp_round_number = rsp_ff.round;
   assign rsp_partner_rank = rsp_ff.partner;
   assign rsp_elem_offset  = rsp_ff.offset;
   assign rsp_elem_total   = rsp_ff.total;
   assign rsp_last_action  = rsp_last_ff;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tree gather schedule block
// drives rank requests under random flow control across many process count,
// root and element count settings and checks every schedule beat in order
// ----------------------------------------------------------------------------
module tb;
   import tgs_pkg::*;

   localparam int PROC_CAP     = 1024;
   localparam int MAX_BEATS    = 12;     // cap on beats per rank; one rank produces at most 11
   localparam int DRAIN_CYCLES = 24;     // closing steps after the last beat
   localparam int HOLD_CYCLES  = 300;    // long response back-pressure
   localparam int LIMIT        = 1000000;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ROUND_W-1:0] round_no;
      logic [RANK_W-1:0]  partner;
      logic [FIELD_W-1:0] offset;
      logic [FIELD_W-1:0] total;
      logic               last;
   } sched_beat_type;

   logic                   clock;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_ready;
   logic [RANK_W-1:0]      req_my_rank  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready    = 1'b0;
   logic [KIND_W-1:0]      rsp_action_kind;
   logic [ROUND_W-1:0]     rsp_round_number;
   logic [RANK_W-1:0]      rsp_partner_rank;
   logic [FIELD_W-1:0]     rsp_elem_offset;
   logic [FIELD_W-1:0]     rsp_elem_total;
   logic                   rsp_last_action;
   logic                   csr_write_en = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   // shadow copy of the block's registers, reset values
   logic [NP_W-1:0]        cfg_procs = 11'd1;
   logic [RANK_W-1:0]      cfg_root  = '0;
   logic [ELEM_W-1:0]      cfg_elems = 16'd1;

   logic [RANK_W-1:0]      pending_ranks[$];   // ranks waiting to be offered
   sched_beat_type         sched_due[$];       // beats the block still owes
   sched_beat_type         plan_buf[$];
   sched_beat_type         got_beat;
   sched_beat_type         want_beat;
   int                     offered_items  = 0;
   int                     accepted_items = 0;
   int                     mismatches     = 0;
   int                     cycles         = 0;
   int                     req_gap        = 0;
   int                     rsp_stall      = 0;
   logic                   calm           = 1'b0;  // no idling on either side
   logic                   hold_rsp       = 1'b0;

   tree_gather_schedule #(
      .MAX_PROCS(PROC_CAP)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_my_rank      (req_my_rank),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_action_kind  (rsp_action_kind),
      .rsp_round_number (rsp_round_number),
      .rsp_partner_rank (rsp_partner_rank),
      .rsp_elem_offset  (rsp_elem_offset),
      .rsp_elem_total   (rsp_elem_total),
      .rsp_last_action  (rsp_last_action),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // schedule predictor
   // ---------------------------------------------------------------------

   function automatic void add_beat(input logic [KIND_W-1:0] kind, input int unsigned rnd,
                                    input int unsigned peer, input int unsigned off,
                                    input int unsigned tot);
      sched_beat_type b;
      if (plan_buf.size() >= MAX_BEATS) return;
      b.kind     = kind;
      b.round_no = rnd[ROUND_W-1:0];
      b.partner  = peer[RANK_W-1:0];
      b.offset   = off[FIELD_W-1:0];
      b.total    = tot[FIELD_W-1:0];
      b.last     = 1'b0;
      plan_buf.push_back(b);
   endfunction

   // works out the whole schedule of one rank and queues its beats
   function automatic void plan_schedule(input logic [RANK_W-1:0] rank);
      int unsigned np, mid, lg, max_gap, gap, stride, peer, stop, second;
      int unsigned me, ne, root, rnd;
      np   = cfg_procs;
      me   = rank;
      ne   = cfg_elems;
      root = cfg_root;
      plan_buf.delete();
      // out-of-range process counts are clamped
      if (np < 1) np = 1;
      if (np > PROC_CAP) np = PROC_CAP;
      mid = 1;
      lg  = 0;
      while (mid < np) begin
         mid = mid * 2;
         lg++;
      end
      mid = mid / 2;
      // a nonzero root stops the tree one round early
      max_gap = (root != 0) ? mid / 2 : mid;
      gap     = 1;
      stride  = 2;
      rnd     = 0;
      while (gap <= max_gap) begin
         if (me % stride == 0) begin
            peer = me + gap;
            if (peer < np) begin
               stop = (peer + gap > np) ? np : peer + gap;
               add_beat(KIND_RECV, rnd, peer, gap * ne, ne * (stop - peer));
            end
         end else begin
            // chunk clipped at the process count, empty for ranks beyond it
            stop = (me + gap > np) ? np : me + gap;
            add_beat(KIND_SEND, rnd, me - gap, 0, (stop > me) ? ne * (stop - me) : 0);
            break;
         end
         rnd++;
         gap    = gap * 2;
         stride = stride * 2;
      end
      // final round toward a nonzero root
      if (root != 0) begin
         second = np - mid;
         if (me == root) begin
            if (root == mid) add_beat(KIND_SHUF, lg, me, mid * ne, second * ne);
            add_beat(KIND_RECV, lg, 0, 0, ne * mid);
            if (mid != root) add_beat(KIND_RECV, lg, mid, mid * ne, ne * second);
         end
         if (me == 0) add_beat(KIND_SEND, lg, root, 0, ne * mid);
         if (me == mid && mid != root) add_beat(KIND_SEND, lg, root, 0, ne * second);
      end
      if (plan_buf.size() == 0) add_beat(KIND_NONE, 0, 0, 0, 0);
      plan_buf[plan_buf.size() - 1].last = 1'b1;
      foreach (plan_buf[i]) sched_due.push_back(plan_buf[i]);
   endfunction

   // ---------------------------------------------------------------------
   // flow control helpers and reporting
   // ---------------------------------------------------------------------

   // idle length: mostly none, some short, a few long
   function automatic int draw_gap();
      int pick;
      if (calm) return 0;
      pick = $urandom_range(99);
      if (pick < 65) return 0;
      if (pick < 92) return $urandom_range(3, 1);
      return $urandom_range(30, 6);
   endfunction

   function automatic string fmt_beat(input sched_beat_type b);
      return $sformatf("kind %0d round %0d partner %0d offset %0d total %0d last %0b",
                       b.kind, b.round_no, b.partner, b.offset, b.total, b.last);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------
   // request driver: offers queued ranks, predicts on each accepted beat
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_my_rank <= '0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            plan_schedule(req_my_rank);
            accepted_items++;
         end
         // payload only moves once the current beat is gone
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_ranks.size() > 0) begin
               req_valid   <= 1'b1;
               req_my_rank <= pending_ranks.pop_front();
               req_gap = draw_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // response monitor: checks each accepted beat against the oldest one owed
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_beat.kind     = rsp_action_kind;
            got_beat.round_no = rsp_round_number;
            got_beat.partner  = rsp_partner_rank;
            got_beat.offset   = rsp_elem_offset;
            got_beat.total    = rsp_elem_total;
            got_beat.last     = rsp_last_action;
            if (sched_due.size() == 0) begin
               report_mismatch({"unexpected beat: ", fmt_beat(got_beat)});
            end else begin
               want_beat = sched_due.pop_front();
               if (got_beat !== want_beat)
                  report_mismatch({"got ", fmt_beat(got_beat),
                                   " / want ", fmt_beat(want_beat)});
            end
         end
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall = draw_gap();
         end
      end
   end

   // long receiver hold-off early in the random part, so the block backs up
   initial begin
      wait (reset == 1'b0);
      wait (accepted_items >= 40);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   task automatic offer(input int unsigned rank);
      pending_ranks.push_back(rank[RANK_W-1:0]);
      offered_items++;
   endtask

   // caller sits just after a rising edge; each write is taken at the next rising edge
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      case (idx)
         CSR_PROC_COUNT: cfg_procs = data[NP_W-1:0];
         CSR_ROOT_RANK:  cfg_root  = data[RANK_W-1:0];
         CSR_ELEM_COUNT: cfg_elems = data[ELEM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] np_word,
                             input logic [CSR_DATA_W-1:0] root_word,
                             input logic [CSR_DATA_W-1:0] elem_word);
      write_csr(CSR_PROC_COUNT, np_word);
      write_csr(CSR_ROOT_RANK, root_word);
      write_csr(CSR_ELEM_COUNT, elem_word);
      csr_write_en <= 1'b0;
   endtask

   // every rank accepted, every beat back, sequencer through its closing steps
   task automatic drain();
      while (accepted_items != offered_items || sched_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(input int n_items);
      int unsigned np, eff, mid, root, ne, pick, rank;
      pick = $urandom_range(99);
      if (pick < 30) np = $urandom_range(16, 1);
      else if (pick < 70) np = $urandom_range(PROC_CAP, 1);
      else if (pick < 85) begin
         case ($urandom_range(4))
            0: np = 0;
            1: np = 1;
            2: np = 2;
            3: np = PROC_CAP;
            default: np = 2047;
         endcase
      end else np = $urandom_range(2047, PROC_CAP + 1);
      eff = (np < 1) ? 1 : (np > PROC_CAP) ? PROC_CAP : np;
      mid = 1;
      while (mid < eff) mid = mid * 2;
      mid = mid / 2;
      pick = $urandom_range(99);
      if (pick < 35) root = 0;
      else if (pick < 50) root = mid;
      else if (pick < 85) root = $urandom_range(eff - 1, 0);
      else root = $urandom_range(1023, 0);
      pick = $urandom_range(99);
      if (pick < 5) ne = 0;
      else if (pick < 25) ne = 1;
      else if (pick < 45) ne = 16'hFFFF;
      else ne = $urandom_range(16'hFFFF, 1);
      calm <= ($urandom_range(3) == 0);
      // unused upper bits of the write word are filled with noise
      set_config({5'($urandom), np[NP_W-1:0]}, {6'($urandom), root[RANK_W-1:0]},
                 ne[ELEM_W-1:0]);
      repeat (n_items) begin
         pick = $urandom_range(99);
         if (pick < 75) rank = $urandom_range(eff - 1, 0);
         else if (pick < 88) begin
            case ($urandom_range(3))
               0: rank = 0;
               1: rank = eff - 1;
               2: rank = root;
               default: rank = mid;
            endcase
         end else rank = $urandom_range(1023, 0);
         offer(rank);
      end
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: single process, nothing to do
      offer(0); offer(1023);
      drain();
      // full tree to root 0, widest element count
      set_config(16'd1024, 16'd0, 16'hFFFF);
      offer(0); offer(1); offer(512); offer(1023); offer(682);
      drain();
      // root at the midpoint: shuffle plus a receive from rank 0
      set_config(16'd1000, 16'd512, 16'hFFFF);
      offer(512); offer(0); offer(999); offer(1023); offer(768);
      drain();
      // small odd count, root inside the first half
      set_config(16'd13, 16'd5, 16'd3);
      offer(5); offer(0); offer(8); offer(12); offer(13);
      drain();
      // zero process count seen as one, root far above it
      set_config(16'hF800, 16'hFFFF, 16'd1);
      offer(0); offer(1);
      drain();
      // process count above the cap
      set_config(16'd2047, 16'd1, 16'd2);
      offer(1); offer(0); offer(512);
      drain();

      repeat (8) random_phase(60);

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
